FILE: design/nd_transpose_address_generator_top_assert.svh
// Assertion macros used by the checker file of the transpose address generator.
`ifndef ND_TRANSPOSE_ADDRESS_GENERATOR_TOP_ASSERT_SVH
`define ND_TRANSPOSE_ADDRESS_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define NDT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define NDT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/ndt_pkg.sv
// Package: widths, register indexes and reset values of the transpose address generator.
`default_nettype none
package ndt_pkg;

	localparam int ELEMENT_BITS   = 32;
	localparam int OFFSET_BITS    = 32;
	localparam int SIZE_BITS      = 16;
	localparam int COUNT_BITS     = 3;
	localparam int PERM_BITS      = 8;
	localparam int SIZE_REGS      = 4;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_AXIS_COUNT = 3'd0,
		CFG_AXIS0_SIZE = 3'd1,
		CFG_AXIS1_SIZE = 3'd2,
		CFG_AXIS2_SIZE = 3'd3,
		CFG_AXIS3_SIZE = 3'd4,
		CFG_AXIS_PERM  = 3'd5
	} cfg_index_t;

	localparam logic [COUNT_BITS-1:0] COUNT_RESET = 3'd4;
	localparam logic [SIZE_BITS-1:0]  SIZE_RESET  = 16'd1;
	localparam logic [PERM_BITS-1:0]  PERM_RESET  = 8'd228;

endpackage
`default_nettype wire

FILE: design/nd_transpose_address_generator_top.sv
// Top level: odometer, axis permutation and pipelined row-major offset fold.
//
// Usage
//   Input channel (in_valid / in_stall): one beat per source element, in source
//   row-major order, with restart to zero the coordinate odometer first.
//   Output channel (out_valid / out_stall): one beat per element with the
//   destination offset in the transposed array, the element bits unchanged and
//   last_element on the final element of the source array.
//   Configuration (cfg_wr_en / cfg_index / cfg_data): write while no beat is in
//   flight; takes effect on the next accepted element.
// Timing
//   The pipeline has one register after the odometer and permutation, then one
//   multiply-add stage per further destination axis (a 32x16 product each).
//   Throughput is one element per cycle while the output is not stalled. Each
//   stage advances on its own, so empty stages fill while the output is
//   stalled; in_stall rises only once the whole pipeline holds data and
//   out_stall is high.
// Reset
//   arst_n clears the odometer, all stage valids and loads the register reset
//   values: four axes, all lengths 1, identity permutation.
`default_nettype none
module nd_transpose_address_generator_top #(
	parameter int MAX_AXES = 4
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [ndt_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire logic [ndt_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic                                 restart,
	input  wire logic [ndt_pkg::ELEMENT_BITS-1:0]     element_value,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [ndt_pkg::OFFSET_BITS-1:0]           dest_offset,
	output logic [ndt_pkg::ELEMENT_BITS-1:0]          moved_value,
	output logic                                      last_element
);

	localparam int AX = (MAX_AXES < ndt_pkg::SIZE_REGS) ? MAX_AXES : ndt_pkg::SIZE_REGS;
	localparam int SB = ndt_pkg::SIZE_BITS;
	localparam int OB = ndt_pkg::OFFSET_BITS;
	localparam int EB = ndt_pkg::ELEMENT_BITS;
	localparam int CB = ndt_pkg::COUNT_BITS;
	localparam logic [CB-1:0] AX_N = CB'(AX);

	// configuration registers
	logic [CB-1:0]                 count_q;
	logic [SB-1:0]                 size_q [ndt_pkg::SIZE_REGS];
	logic [ndt_pkg::PERM_BITS-1:0] perm_q;

	// odometer
	logic [SB-1:0] coord_q [AX];

	logic [CB-1:0] n_eff;
	logic [AX-1:0] act;
	logic [AX-1:0] wrap;
	logic [AX-1:0] carry;
	logic [SB-1:0] cur  [AX];
	logic [SB-1:0] len  [AX];
	logic [SB-1:0] nxt  [AX];
	logic [SB-1:0] dcrd [AX];
	logic [SB-1:0] dlen [AX];
	logic          last_c;

	// pipeline
	logic [AX:0]      rdy;
	logic [AX-1:0]    vld_s;
	logic [OB-1:0]    off_s  [AX];
	logic [SB-1:0]    crd_s  [AX][AX];
	logic [EB-1:0]    val_s  [AX];
	logic             last_s [AX];
	logic [OB+SB-1:0] prod   [AX];
	logic [OB-1:0]    stg_sum [AX];

	logic in_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= ndt_pkg::COUNT_RESET;
			perm_q  <= ndt_pkg::PERM_RESET;
			for (int i = 0; i < ndt_pkg::SIZE_REGS; i++) begin
				size_q[i] <= ndt_pkg::SIZE_RESET;
			end
		end else if (cfg_wr_en) begin
			case (cfg_index)
				ndt_pkg::CFG_AXIS_COUNT: count_q   <= cfg_data[CB-1:0];
				ndt_pkg::CFG_AXIS0_SIZE: size_q[0] <= cfg_data[SB-1:0];
				ndt_pkg::CFG_AXIS1_SIZE: size_q[1] <= cfg_data[SB-1:0];
				ndt_pkg::CFG_AXIS2_SIZE: size_q[2] <= cfg_data[SB-1:0];
				ndt_pkg::CFG_AXIS3_SIZE: size_q[3] <= cfg_data[SB-1:0];
				ndt_pkg::CFG_AXIS_PERM:  perm_q    <= cfg_data[ndt_pkg::PERM_BITS-1:0];
				default: ;
			endcase
		end
	end

	// clamp the axis count to 1..AX; counts above AX behave as AX
	always_comb begin
		if (count_q == '0) begin
			n_eff = CB'(1);
		end else if (count_q > AX_N) begin
			n_eff = AX_N;
		end else begin
			n_eff = count_q;
		end
	end

	// odometer advance: innermost used axis counts fastest
	always_comb begin
		for (int a = 0; a < AX; a++) begin
			act[a]  = CB'(a) < n_eff;
			len[a]  = (!act[a] || size_q[a] == '0) ? SB'(1) : size_q[a];
			cur[a]  = restart ? '0 : coord_q[a];
			wrap[a] = ({1'b0, cur[a]} + (SB+1)'(1)) >= {1'b0, len[a]};
		end
		carry[AX-1] = 1'b1;
		for (int a = AX - 2; a >= 0; a--) begin
			// unused axes have length 1 and pass the carry on
			carry[a] = carry[a+1] & wrap[a+1];
		end
		for (int a = 0; a < AX; a++) begin
			if (act[a] && carry[a]) begin
				nxt[a] = wrap[a] ? '0 : cur[a] + SB'(1);
			end else begin
				nxt[a] = cur[a];
			end
		end
		last_c = carry[0] & wrap[0];
	end

	// permute source coordinates and lengths onto destination axes
	always_comb begin
		for (int j = 0; j < AX; j++) begin
			dcrd[j] = '0;
			dlen[j] = SB'(1);
			if (CB'(j) < n_eff) begin
				for (int a = 0; a < AX; a++) begin
					if (perm_q[2*j +: 2] == 2'(a) && act[a]) begin
						dcrd[j] = cur[a];
						dlen[j] = len[a];
					end
				end
			end
		end
	end

	// per-stage ready: a stage loads when empty or when the next one moves
	always_comb begin
		rdy[AX] = !out_stall;
		for (int k = AX - 1; k >= 0; k--) begin
			rdy[k] = !vld_s[k] | rdy[k+1];
		end
	end

	assign in_stall = !rdy[0];
	assign in_fire  = in_valid & rdy[0];

	always_comb begin
		prod[0]    = '0;
		stg_sum[0] = '0;
		for (int k = 1; k < AX; k++) begin
			prod[k]    = {{SB{1'b0}}, off_s[k-1]} * {{OB{1'b0}}, dlen[k]};
			stg_sum[k] = prod[k][OB-1:0] + {{(OB-SB){1'b0}}, crd_s[k-1][k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			for (int a = 0; a < AX; a++) begin
				coord_q[a] <= '0;
			end
		end else begin
			if (rdy[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k < AX; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
			// advance the odometer on every accepted beat
			if (in_fire) begin
				coord_q <= nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			off_s[0]  <= {{(OB-SB){1'b0}}, dcrd[0]};
			crd_s[0]  <= dcrd;
			val_s[0]  <= element_value;
			last_s[0] <= last_c;
		end
		for (int k = 1; k < AX; k++) begin
			if (rdy[k] && vld_s[k-1]) begin
				off_s[k]  <= stg_sum[k];
				crd_s[k]  <= crd_s[k-1];
				val_s[k]  <= val_s[k-1];
				last_s[k] <= last_s[k-1];
			end
		end
	end

	assign out_valid    = vld_s[AX-1];
	assign dest_offset  = off_s[AX-1];
	assign moved_value  = val_s[AX-1];
	assign last_element = last_s[AX-1];

endmodule
`default_nettype wire

FILE: design/ndt_assert_chk.sv
// Port checker for the transpose address generator, bound to the top level.
`default_nettype none
`include "nd_transpose_address_generator_top_assert.svh"
module ndt_assert_chk (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               cfg_wr_en,
	input wire logic [ndt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input wire logic [ndt_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input wire logic                               in_valid,
	input wire logic                               in_stall,
	input wire logic                               restart,
	input wire logic [ndt_pkg::ELEMENT_BITS-1:0]   element_value,
	input wire logic                               out_valid,
	input wire logic                               out_stall,
	input wire logic [ndt_pkg::OFFSET_BITS-1:0]    dest_offset,
	input wire logic [ndt_pkg::ELEMENT_BITS-1:0]   moved_value,
	input wire logic                               last_element
);

	// a stalled result beat stays offered
	`NDT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped under stall")

	// a stalled result beat keeps its payload
	`NDT_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(dest_offset) && $stable(moved_value) && $stable(last_element), "result payload changed under stall")

	// the input is stalled only when the output is full and stalled
	`NDT_ASSERT_SAME(a_in_open, !out_valid || !out_stall, !in_stall, "input stalled with the output free")

endmodule

bind nd_transpose_address_generator_top ndt_assert_chk u_ndt_assert_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_wr_en     (cfg_wr_en),
	.cfg_index     (cfg_index),
	.cfg_data      (cfg_data),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.restart       (restart),
	.element_value (element_value),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.dest_offset   (dest_offset),
	.moved_value   (moved_value),
	.last_element  (last_element)
);
`default_nettype wire
